FILE: sv/bpfa_pkg.sv
// shared types, sizes and codes for the bitmap page frame allocator
// no dependencies; imported by every module of the block
`default_nettype none

package bpfa_pkg;

  // sizing
  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 24;
  localparam int CNT_W      = 13;
  localparam int PIDX_W     = $clog2(NUM_PAGES);
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NWORDS     = NUM_PAGES / WORD_W;
  localparam int WIDX_W     = $clog2(NWORDS);
  localparam int STEP       = 8;
  localparam int STEP_W     = $clog2(STEP);

  // request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_EXCEEDS = 3'd2;
  localparam logic [2:0] ST_NORUN   = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_ALLOC,
    CMD_FREE
  } cmd_kind_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] frame_address;
    logic [CNT_W-1:0]  page_count;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] run_address;
    logic [CNT_W-1:0]  free_pages;
  } rsp_t;

  // classified item passed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [2:0]        status;
    logic [CNT_W-1:0]  count;
    logic [PIDX_W-1:0] idx;
    logic [CNT_W-1:0]  total;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/bpfa_front.sv
// front end: takes items, holds the page limit register, classifies requests
// depends on bpfa_pkg
`default_nettype none

module bpfa_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  bpfa_pkg::req_t    req,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [12:0]        cfg_data,
  input  wire [12:0]        free_pages,
  input  wire               done,
  output logic              push,
  output bpfa_pkg::cmd_t    cmd
);
  import bpfa_pkg::*;

  logic [CNT_W-1:0] pages_in_use;
  logic [CNT_W-1:0] total;
  logic [CNT_W:0]   free_end;
  logic [PIDX_W-1:0] idx;

  assign cfg_ready = 1'b1;
  assign push      = start && !busy;

  // page limit register and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= CNT_W'(NUM_PAGES);
      busy         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) pages_in_use <= cfg_data;
      if (push) busy <= 1'b1;
      else if (done) busy <= 1'b0;
    end
  end

  // classify the item
  always_comb begin
    total    = (pages_in_use > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : pages_in_use;
    idx      = req.frame_address[ADDR_W-1 -: PIDX_W];
    free_end = (CNT_W+1)'(idx) + (CNT_W+1)'(req.page_count);
    cmd.status = ST_OK;
    cmd.count  = req.page_count;
    cmd.idx    = idx;
    cmd.total  = total;
    cmd.kind   = CMD_REPORT;
    if (req.func == FUNC_ALLOC) begin
      if (req.page_count == '0) cmd.status = ST_ZERO;
      else if (req.page_count > free_pages) cmd.status = ST_EXCEEDS;
      else cmd.kind = CMD_ALLOC;
    end else begin
      if (req.page_count == '0) cmd.status = ST_OK;
      else if (free_end > (CNT_W+1)'(total)) cmd.status = ST_RANGE;
      else cmd.kind = CMD_FREE;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bpfa_queue.sv
// two-entry queue of classified items between front and back
// depends on bpfa_pkg
`default_nettype none

module bpfa_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  bpfa_pkg::cmd_t push_cmd,
  input  wire            pop,
  output logic           valid,
  output bpfa_pkg::cmd_t head
);
  import bpfa_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign valid = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && fill != 2'd2) wr_ptr <= !wr_ptr;
      if (pop && valid) rd_ptr <= !rd_ptr;
      case ({push && fill != 2'd2, pop && valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push && fill != 2'd2) slots[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

FILE: sv/bpfa_back.sv
// back end: page map memory, first-fit scan and run marking, free counter
// depends on bpfa_pkg
`default_nettype none

module bpfa_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               cmd_valid,
  input  bpfa_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              done,
  output bpfa_pkg::rsp_t    result,
  output logic [12:0]       free_pages
);
  import bpfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_BIT,
    S_MARK_RD,
    S_MARK_WR
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [CNT_W-1:0]  p;
  logic [CNT_W-1:0]  run;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W:0]    hi;
  logic [WIDX_W-1:0] w;
  logic [CNT_W-1:0]  free_cnt;

  // page map memory, one valid bit per word (invalid reads as all used)
  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] word_valid;
  logic [WORD_W-1:0] mem_q;
  logic              valid_q;
  logic              rd_en;
  logic [WIDX_W-1:0] rd_addr;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] word;

  // scan step signals
  logic              s_found;
  logic              s_stop;
  logic [CNT_W-1:0]  s_run;
  logic [CNT_W-1:0]  s_pos;
  logic [CNT_W-1:0]  s_fpos;
  logic [CNT_W-1:0]  s_p_next;
  logic [CNT_W-1:0]  s_start;

  // mark step signals
  logic [WORD_W-1:0] mask;
  logic [CNT_W:0]    bit_addr;
  logic [CNT_W:0]    word_end;
  logic [CNT_W:0]    sum;

  assign free_pages = free_cnt;
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign rd_en      = (state == S_SCAN_RD) || (state == S_MARK_RD);
  assign rd_addr    = (state == S_SCAN_RD) ? p[PIDX_W-1:BIT_W] : w;
  assign wr_en      = (state == S_MARK_WR);
  assign word       = valid_q ? mem_q : '1;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[w] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (wr_en) word_valid[w] <= 1'b1;
      if (rd_en) valid_q <= word_valid[rd_addr];
    end
  end

  // one byte of the scan: extend or break the current free run
  always_comb begin
    s_found = 1'b0;
    s_stop  = 1'b0;
    s_run   = run;
    s_fpos  = '0;
    s_pos   = '0;
    for (int j = 0; j < STEP; j++) begin
      s_pos = p + CNT_W'(j);
      if (!s_found && !s_stop) begin
        if (s_pos >= cur.total) begin
          s_stop = 1'b1;
        end else if (word[{p[BIT_W-1:STEP_W], STEP_W'(j)}]) begin
          s_run = '0;
        end else begin
          s_run = s_run + CNT_W'(1);
          if (s_run == cur.count) begin
            s_found = 1'b1;
            s_fpos  = s_pos;
          end
        end
      end
    end
    s_p_next = p + CNT_W'(STEP);
    s_start  = s_fpos + CNT_W'(1) - cur.count;
  end

  // per-word mask of pages inside [lo, hi)
  always_comb begin
    bit_addr = '0;
    for (int b = 0; b < WORD_W; b++) begin
      bit_addr = (CNT_W+1)'({w, BIT_W'(b)});
      mask[b]  = (bit_addr >= (CNT_W+1)'(lo)) && (bit_addr < hi);
    end
    wr_data  = (cur.kind == CMD_ALLOC) ? (word | mask) : (word & ~mask);
    word_end = (CNT_W+1)'({w, BIT_W'(0)}) + (CNT_W+1)'(WORD_W);
    sum      = (CNT_W+1)'(free_cnt) + (CNT_W+1)'(cur.count);
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      free_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            case (cmd.kind)
              CMD_ALLOC: begin
                p     <= '0;
                run   <= '0;
                state <= S_SCAN_RD;
              end
              CMD_FREE: begin
                lo    <= CNT_W'(cmd.idx);
                hi    <= (CNT_W+1)'(cmd.idx) + (CNT_W+1)'(cmd.count);
                w     <= cmd.idx[PIDX_W-1:BIT_W];
                state <= S_MARK_RD;
              end
              default: begin
                done               <= 1'b1;
                result.status      <= cmd.status;
                result.run_address <= '0;
                result.free_pages  <= free_cnt;
              end
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_BIT;
        S_SCAN_BIT: begin
          if (s_found) begin
            lo    <= s_start;
            hi    <= (CNT_W+1)'(s_start) + (CNT_W+1)'(cur.count);
            w     <= s_start[PIDX_W-1:BIT_W];
            state <= S_MARK_RD;
          end else if (s_stop) begin
            done               <= 1'b1;
            result.status      <= ST_NORUN;
            result.run_address <= '0;
            result.free_pages  <= free_cnt;
            state              <= S_IDLE;
          end else begin
            p   <= s_p_next;
            run <= s_run;
            if (s_p_next[BIT_W-1:0] == '0) state <= S_SCAN_RD;
          end
        end
        S_MARK_RD: state <= S_MARK_WR;
        S_MARK_WR: begin
          if (word_end >= hi) begin
            done          <= 1'b1;
            result.status <= ST_OK;
            state         <= S_IDLE;
            if (cur.kind == CMD_ALLOC) begin
              free_cnt           <= free_cnt - cur.count;
              result.free_pages  <= free_cnt - cur.count;
              result.run_address <= ADDR_W'(lo) << PAGE_SHIFT;
            end else begin
              free_cnt           <= (sum > (CNT_W+1)'(cur.total)) ? cur.total : sum[CNT_W-1:0];
              result.free_pages  <= (sum > (CNT_W+1)'(cur.total)) ? cur.total : sum[CNT_W-1:0];
              result.run_address <= '0;
            end
          end else begin
            w     <= w + WIDX_W'(1);
            state <= S_MARK_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/bitmap_page_frame_allocator.sv
// Flow: a rejected or empty request is answered from the idle state; a free reads
// and writes back each touched 64-page map word; an allocate reads each scanned map
// word and tests it one byte at a time, then reads and writes back each marked word.
// Throughput: one item at a time; busy falls in the cycle after done, and only then
// is the next item taken. The receiver cannot stall. Reset: all pages used, free
// count zero, page limit 4096; per-word valid bits make the map read as used at once.
`default_nettype none

module bitmap_page_frame_allocator (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  bpfa_pkg::req_t  req,
  output logic            done,
  output bpfa_pkg::rsp_t  result,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire [12:0]      cfg_data
);
  import bpfa_pkg::*;

  cmd_t             push_cmd;
  cmd_t             head;
  logic             push;
  logic             q_valid;
  logic             pop;
  logic [CNT_W-1:0] free_pages;

  // front end
  bpfa_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .free_pages(free_pages), .done(done), .push(push), .cmd(push_cmd)
  );

  // item queue
  bpfa_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd),
    .pop(pop), .valid(q_valid), .head(head)
  );

  // back end
  bpfa_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd(head), .cmd_pop(pop),
    .done(done), .result(result), .free_pages(free_pages)
  );

endmodule

`default_nettype wire

FILE: sv/bpfa_checker.sv
// port-level checks for the allocator, bound to the top level
// depends on bpfa_pkg
`default_nettype none

module bpfa_checker (
  input wire            clk,
  input wire            rst,
  input wire            start,
  input wire            busy,
  input wire            done,
  input bpfa_pkg::rsp_t result
);
  import bpfa_pkg::*;

  // a result only comes while an item is open
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without an open item");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after accept");

  // a result closes the item
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after result");

  // a failed request returns no address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.run_address == '0))
    else $error("address on failed request");

  // free count stays within the map
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.free_pages <= 13'(NUM_PAGES)))
    else $error("free count out of range");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

`default_nettype wire
